// ----- rtl/htcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, codes, constants and the lane control type of the Hall trackball block.
package htcd_pkg;

	localparam int DEF_CALIB_SAMPLES = 16;
	localparam int DEF_SAMPLE_BITS   = 12;
	localparam int NUM_CH            = 4;

	localparam int FUNC_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int SENS_W     = 8;
	localparam int NOISE_W    = 15;
	localparam int LIMIT_W    = 12;
	localparam int LIM2_W     = 2 * LIMIT_W;
	localparam int DELTA_W    = 16;
	localparam int CONF_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [FUNC_W-1:0] FUNC_CALIB = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PDOWN = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MOTION    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SENS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

	localparam logic [SENS_W-1:0]  SENS_RESET  = 8'd10;
	localparam logic [NOISE_W-1:0] NOISE_RESET = 15'd8;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd20;

	// Divide by ten: magnitudes are saturated to 327680 first, which already
	// clamps, so a 19 bit reciprocal with a 22 bit shift is exact.
	localparam int               MAG_W       = 19;
	localparam logic [MAG_W-1:0] MAG_SAT     = 19'd327680;
	localparam logic [MAG_W-1:0] RECIP       = 19'd419431;
	localparam int               RECIP_SHIFT = 22;

	localparam logic [DELTA_W-1:0] DELTA_MAX = 16'd32767;
	localparam logic [CONF_W-1:0]  CONF_MAX  = 8'd255;

	typedef struct packed {
		logic load;
		logic acc;
		logic clear;
		logic div_start;
		logic commit;
	} lane_ctrl_t;

endpackage

// ----- rtl/htcd_lane.sv -----
`timescale 1ns / 1ps
// One sensor channel: accumulators, reciprocal mean, variance test and baseline.
module htcd_lane import htcd_pkg::*; #(
	parameter int CALIB_SAMPLES = DEF_CALIB_SAMPLES,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lane_ctrl_t                    ctrl,
	input  logic                          base_we,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic [LIM2_W-1:0]             lim2,
	output logic                          fail,
	output logic signed [SAMPLE_BITS:0]   dev_s1
);

	localparam int NW    = $clog2(CALIB_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_BITS + NW;
	localparam int SQ_W  = 2 * SAMPLE_BITS + NW;
	localparam int MSQ_W = 2 * SAMPLE_BITS;
	localparam int KW    = ((MSQ_W > LIM2_W) ? MSQ_W : LIM2_W) + 1;
	localparam int THR_W = KW + NW;
	localparam int CMP_W = (SQ_W > THR_W) ? SQ_W : THR_W;

	// Mean by reciprocal multiplication, exact for every sum of SUM_W bits.
	localparam int                RS       = SUM_W + $clog2(CALIB_SAMPLES);
	localparam int                RCP_W    = SUM_W + 1;
	localparam int                PRD_W    = SUM_W + RCP_W;
	localparam longint unsigned   RCP_FULL = ((64'd1 << RS) + 64'(CALIB_SAMPLES) - 64'd1) /
		64'(CALIB_SAMPLES);
	localparam logic [RCP_W-1:0]  RCP      = RCP_W'(RCP_FULL);

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] base_q;
	logic [SAMPLE_BITS-1:0] quo_q;
	logic [MSQ_W-1:0]       sq_s1;
	logic [MSQ_W-1:0]       msq_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]        sqsum_q;
	logic [PRD_W-1:0]       mean_prod;
	logic [KW-1:0]          k_q;
	logic [THR_W-1:0]       thr_q;
	logic                   fail_q;

	assign mean_prod = PRD_W'(sum_q) * PRD_W'(RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sqsum_q <= '0;
			base_q  <= '0;
		end else begin
			if (ctrl.clear) begin
				sum_q   <= '0;
				sqsum_q <= '0;
			end else if (ctrl.acc) begin
				sum_q   <= sum_q + SUM_W'(sample_q);
				sqsum_q <= sqsum_q + SQ_W'(sq_s1);
			end
			if (ctrl.commit && base_we) begin
				base_q <= quo_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sample_q <= sample;
			sq_s1    <= MSQ_W'(sample) * MSQ_W'(sample);
		end
		if (ctrl.div_start) begin
			quo_q <= mean_prod[RS +: SAMPLE_BITS];
		end
		// Variance test as avg_sq > mean^2 + lim^2, i.e. sqsum >= N * (mean^2 + lim^2 + 1).
		msq_q  <= MSQ_W'(quo_q) * MSQ_W'(quo_q);
		k_q    <= KW'(msq_q) + KW'(lim2) + KW'(1);
		thr_q  <= THR_W'(k_q) * THR_W'(CALIB_SAMPLES);
		fail_q <= (CMP_W'(sqsum_q) >= CMP_W'(thr_q));
		dev_s1 <= $signed({1'b0, sample_q}) - $signed({1'b0, base_q});
	end

	assign fail = fail_q;

endmodule

// ----- rtl/htcd_merge.sv -----
`timescale 1ns / 1ps
// Combines the lane results: first rejected channel, differentials and confidence.
module htcd_merge import htcd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic [NUM_CH-1:0]             fail,
	input  logic signed [SAMPLE_BITS:0]   dev [NUM_CH],
	output logic [NUM_CH-1:0]             base_we,
	output logic                          all_pass,
	output logic signed [SAMPLE_BITS+1:0] dx_s2,
	output logic signed [SAMPLE_BITS+1:0] dy_s2,
	output logic [CONF_W-1:0]             conf_s3
);

	localparam int AW = SAMPLE_BITS + 1;

	logic          blocked;
	logic [AW-1:0] absd [NUM_CH];
	logic [AW-1:0] max01;
	logic [AW-1:0] max23;
	logic [AW-1:0] maxdev;
	logic [AW-1:0] maxdev_s2;

	// Channels are checked in order; the first rejection freezes the rest.
	always_comb begin
		blocked = 1'b0;
		for (int i = 0; i < NUM_CH; i++) begin
			base_we[i] = !blocked && !fail[i];
			blocked    = blocked || fail[i];
		end
	end

	assign all_pass = ~|fail;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			absd[i] = dev[i][SAMPLE_BITS] ? AW'(-dev[i]) : AW'(dev[i]);
		end
		max01  = (absd[1] > absd[0]) ? absd[1] : absd[0];
		max23  = (absd[3] > absd[2]) ? absd[3] : absd[2];
		maxdev = (max23 > max01) ? max23 : max01;
	end

	always_ff @(posedge clk) begin
		dx_s2     <= (AW+1)'(dev[0]) - (AW+1)'(dev[1]);
		dy_s2     <= (AW+1)'(dev[2]) - (AW+1)'(dev[3]);
		maxdev_s2 <= maxdev;
		conf_s3   <= (maxdev_s2 >= AW'(CONF_MAX)) ? '0 : CONF_MAX - maxdev_s2[CONF_W-1:0];
	end

endmodule

// ----- rtl/htcd_scale.sv -----
`timescale 1ns / 1ps
// Sensitivity scaling, truncating divide by ten, clamping and motion detection.
module htcd_scale import htcd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic signed [SAMPLE_BITS+1:0] dx,
	input  logic signed [SAMPLE_BITS+1:0] dy,
	input  logic [SENS_W-1:0]             sens,
	input  logic [NOISE_W-1:0]            noise,
	output logic signed [DELTA_W-1:0]     delta_x,
	output logic signed [DELTA_W-1:0]     delta_y,
	output logic                          moving
);

	localparam int DW   = SAMPLE_BITS + 2;
	localparam int PW   = DW + SENS_W + 1;
	localparam int QP_W = 2 * MAG_W;

	logic signed [DW-1:0]      diff     [2];
	logic signed [PW-1:0]      prod_s3  [2];
	logic [PW-1:0]             mag      [2];
	logic [MAG_W-1:0]          mag_s4   [2];
	logic                      neg_s4   [2];
	logic [QP_W-1:0]           qp       [2];
	logic [DELTA_W-1:0]        q_s5     [2];
	logic                      neg_s5   [2];
	logic [DELTA_W-1:0]        clamped  [2];
	logic signed [DELTA_W-1:0] delta_s6 [2];
	logic [DELTA_W-1:0]        amag     [2];
	logic [1:0]                over;

	assign diff[0] = dx;
	assign diff[1] = dy;

	for (genvar a = 0; a < 2; a++) begin : g_axis
		always_comb begin
			mag[a]     = prod_s3[a][PW-1] ? PW'(-prod_s3[a]) : PW'(prod_s3[a]);
			qp[a]      = QP_W'(mag_s4[a]) * QP_W'(RECIP);
			clamped[a] = (q_s5[a] > DELTA_MAX) ? DELTA_MAX : q_s5[a];
			amag[a]    = delta_s6[a][DELTA_W-1] ? DELTA_W'(-delta_s6[a]) : DELTA_W'(delta_s6[a]);
			over[a]    = (amag[a][DELTA_W-2:0] > noise);
		end

		always_ff @(posedge clk) begin
			prod_s3[a]  <= PW'(diff[a]) * $signed({1'b0, sens});
			mag_s4[a]   <= (mag[a] >= PW'(MAG_SAT)) ? MAG_SAT : mag[a][MAG_W-1:0];
			neg_s4[a]   <= prod_s3[a][PW-1];
			q_s5[a]     <= qp[a][RECIP_SHIFT +: DELTA_W];
			neg_s5[a]   <= neg_s4[a];
			delta_s6[a] <= neg_s5[a] ? -$signed(clamped[a]) : $signed(clamped[a]);
		end
	end

	assign delta_x = delta_s6[0];
	assign delta_y = delta_s6[1];
	assign moving  = |over;

endmodule

// ----- rtl/hall_trackball_calib_and_delta_top.sv -----
`timescale 1ns / 1ps
// Top level of the Hall trackball calibration and differential delta block.
//
// Usage. The input channel (in_valid/in_ready) carries one beat per item: a
// function code and the four Hall samples x+, x-, y+, y-. Code 0 is a
// calibration sample, 1 a read, 2 a power down; code 3 is answered with an
// ok status and changes nothing. Every item yields exactly one result beat
// on the output channel (out_valid/out_ready): status, the two scaled deltas,
// the motion flag and the surface confidence. The configuration channel
// (cfg_valid/cfg_ready, always ready) writes sensitivity, noise threshold
// and calibration motion limit; it should be used only while the block idles.
// The block handles one item at a time and accepts the next only once the
// sequencer is idle again: a power down passes through the write-out state,
// a calibration sample also through the accumulate step, a read through the
// read wait, and the last sample of a calibration through the mean and the
// four register stages of the variance test that follow the mean. The result
// beat is presented from the edge at which in_ready returns high. A
// finished result sits in an output register; if the receiver stalls, the
// block holds the following item until the register frees. Reset clears the
// baselines, sums and counters, drops the calibrated flag and restores the
// register defaults.
module hall_trackball_calib_and_delta_top import htcd_pkg::*; #(
	parameter int CALIB_SAMPLES = DEF_CALIB_SAMPLES,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [FUNC_W-1:0]         func,
	input  logic [SAMPLE_BITS-1:0]    x_pos_sample,
	input  logic [SAMPLE_BITS-1:0]    x_neg_sample,
	input  logic [SAMPLE_BITS-1:0]    y_pos_sample,
	input  logic [SAMPLE_BITS-1:0]    y_neg_sample,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic signed [DELTA_W-1:0] delta_x,
	output logic signed [DELTA_W-1:0] delta_y,
	output logic                      moving,
	output logic [CONF_W-1:0]         confidence,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	localparam int NW       = $clog2(CALIB_SAMPLES + 1);
	// Register depth of the free-running lane tail (square, add, scale, compare)
	// and of the read path from the sample register to the clamped deltas.
	localparam int POST_LAT = 4;
	localparam int READ_LAT = 6;
	localparam int CNT_W    = $clog2(READ_LAT);

	localparam int S_W = 4;
	localparam logic [S_W-1:0] S_IDLE   = 4'd0;
	localparam logic [S_W-1:0] S_ACC    = 4'd1;
	localparam logic [S_W-1:0] S_DLOAD  = 4'd2;
	localparam logic [S_W-1:0] S_POST   = 4'd4;
	localparam logic [S_W-1:0] S_COMMIT = 4'd5;
	localparam logic [S_W-1:0] S_READ   = 4'd6;
	localparam logic [S_W-1:0] S_WR     = 4'd7;

	logic [S_W-1:0]        state_q;
	logic [CNT_W-1:0]      seq_cnt_q;
	logic [NW-1:0]         cnt_q;
	logic                  ready_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  res_read_q;

	logic [SENS_W-1:0]     sens_q;
	logic [NOISE_W-1:0]    noise_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic [LIM2_W-1:0]     lim2_q;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic signed [DELTA_W-1:0] delta_x_q;
	logic signed [DELTA_W-1:0] delta_y_q;
	logic                      moving_q;
	logic [CONF_W-1:0]         conf_q;

	logic                          in_acc;
	logic                          out_free;
	lane_ctrl_t                    ctrl;
	logic [SAMPLE_BITS-1:0]        samp     [NUM_CH];
	logic signed [SAMPLE_BITS:0]   lane_dev [NUM_CH];
	logic [NUM_CH-1:0]             lane_fail;
	logic [NUM_CH-1:0]             base_we;
	logic                          all_pass;
	logic signed [SAMPLE_BITS+1:0] dx_s2;
	logic signed [SAMPLE_BITS+1:0] dy_s2;
	logic [CONF_W-1:0]             conf_s3;
	logic signed [DELTA_W-1:0]     sc_delta_x;
	logic signed [DELTA_W-1:0]     sc_delta_y;
	logic                          sc_moving;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	assign samp[0] = x_pos_sample;
	assign samp[1] = x_neg_sample;
	assign samp[2] = y_pos_sample;
	assign samp[3] = y_neg_sample;

	// Lane control follows the sequencer state; the power down clears the
	// partial sums in the same cycle that it is accepted.
	always_comb begin
		ctrl.load      = in_acc;
		ctrl.acc       = (state_q == S_ACC);
		ctrl.clear     = (in_acc && (func == FUNC_PDOWN)) || (state_q == S_COMMIT);
		ctrl.div_start = (state_q == S_DLOAD);
		ctrl.commit    = (state_q == S_COMMIT);
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		htcd_lane #(
			.CALIB_SAMPLES(CALIB_SAMPLES),
			.SAMPLE_BITS  (SAMPLE_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.base_we(base_we[c]),
			.sample (samp[c]),
			.lim2   (lim2_q),
			.fail   (lane_fail[c]),
			.dev_s1 (lane_dev[c])
		);
	end

	htcd_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk     (clk),
		.fail    (lane_fail),
		.dev     (lane_dev),
		.base_we (base_we),
		.all_pass(all_pass),
		.dx_s2   (dx_s2),
		.dy_s2   (dy_s2),
		.conf_s3 (conf_s3)
	);

	htcd_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk    (clk),
		.dx     (dx_s2),
		.dy     (dy_s2),
		.sens   (sens_q),
		.noise  (noise_q),
		.delta_x(sc_delta_x),
		.delta_y(sc_delta_y),
		.moving (sc_moving)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q  <= SENS_RESET;
			noise_q <= NOISE_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SENS:  sens_q  <= cfg_data[SENS_W-1:0];
				CFG_NOISE: noise_q <= cfg_data[NOISE_W-1:0];
				CFG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// The squared limit only changes with configuration, so it simply tracks it.
	always_ff @(posedge clk) begin
		lim2_q <= LIM2_W'(limit_q) * LIM2_W'(limit_q);
	end

	// Sequencer: one item at a time, from acceptance to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seq_cnt_q    <= '0;
			cnt_q        <= '0;
			ready_q      <= 1'b0;
			res_status_q <= ST_OK;
			res_read_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == S_WR) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_status_q <= ST_OK;
						res_read_q   <= 1'b0;
						seq_cnt_q    <= '0;
						unique case (func)
							FUNC_CALIB: state_q <= S_ACC;
							FUNC_READ: begin
								if (ready_q) begin
									res_read_q <= 1'b1;
									state_q    <= S_READ;
								end else begin
									res_status_q <= ST_NOT_READY;
									state_q      <= S_WR;
								end
							end
							FUNC_PDOWN: begin
								ready_q <= 1'b0;
								cnt_q   <= '0;
								state_q <= S_WR;
							end
							default: state_q <= S_WR;
						endcase
					end
				end
				S_ACC: begin
					if (cnt_q == NW'(CALIB_SAMPLES - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DLOAD;
					end else begin
						cnt_q        <= cnt_q + NW'(1);
						res_status_q <= ST_BUSY;
						state_q      <= S_WR;
					end
				end
				S_DLOAD: begin
					seq_cnt_q <= '0;
					state_q   <= S_POST;
				end
				S_POST: begin
					if (seq_cnt_q == CNT_W'(POST_LAT - 1)) begin
						state_q <= S_COMMIT;
					end else begin
						seq_cnt_q <= seq_cnt_q + CNT_W'(1);
					end
				end
				S_COMMIT: begin
					if (all_pass) begin
						ready_q      <= 1'b1;
						res_status_q <= ST_OK;
					end else begin
						res_status_q <= ST_MOTION;
					end
					state_q <= S_WR;
				end
				S_READ: begin
					if (seq_cnt_q == CNT_W'(READ_LAT - 1)) begin
						state_q <= S_WR;
					end else begin
						seq_cnt_q <= seq_cnt_q + CNT_W'(1);
					end
				end
				S_WR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register; only a successful read carries deltas and confidence.
	always_ff @(posedge clk) begin
		if ((state_q == S_WR) && out_free) begin
			status_q <= res_status_q;
			if (res_read_q) begin
				delta_x_q <= sc_delta_x;
				delta_y_q <= sc_delta_y;
				moving_q  <= sc_moving;
				conf_q    <= conf_s3;
			end else begin
				delta_x_q <= '0;
				delta_y_q <= '0;
				moving_q  <= 1'b0;
				conf_q    <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign delta_x    = delta_x_q;
	assign delta_y    = delta_y_q;
	assign moving     = moving_q;
	assign confidence = conf_q;

	// The calibrated flag is only ever set by a completed calibration check.
	a_ready_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(state_q == S_COMMIT))
		else $error("calibrated flag set outside the calibration check");

	// A passing calibration check leaves the block calibrated.
	a_pass_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) && all_pass |=> ready_q)
		else $error("passing calibration did not set the calibrated flag");

	// The sample counter never reaches the calibration length.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < NW'(CALIB_SAMPLES))
		else $error("calibration sample counter out of range");

	// A new result only appears from the write-out state.
	a_out_from_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_WR))
		else $error("result presented outside the write-out state");

	// A non-read result with a status other than ok carries zero deltas, flag and confidence.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_read_q && (status_q != ST_OK) |->
			(delta_x_q == '0) && (delta_y_q == '0) && !moving_q && (conf_q == '0))
		else $error("non-read result carries payload");

endmodule
